// ----- sv/pgibs_pkg.sv -----
// Shared types and constants of the packed genotype IBS counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pgibs_pkg;

  // Genotype code for a missing call.
  localparam logic [1:0] GenoMissing = 2'd3;

  // Absolute genotype differences that select a count.
  localparam logic [1:0] DiffNone = 2'd0;
  localparam logic [1:0] DiffOne  = 2'd1;
  localparam logic [1:0] DiffTwo  = 2'd2;

  // Width of each count field on the result word.
  localparam int unsigned CntOutW  = 32;
  localparam int unsigned OutDataW = 3 * CntOutW;

  // One-hot class of a single marker slot; all zero when either call is missing.
  typedef struct packed {
    logic ibs0;
    logic ibs1;
    logic ibs2;
  } lane_hit_t;

  // Run markers that travel with a word through the pipeline.
  typedef struct packed {
    logic first;
    logic last;
  } word_flags_t;

endpackage

// ----- sv/pgibs_lane.sv -----
// One marker lane: classifies a pair of 2-bit genotype calls by IBS state.
// Depends on pgibs_pkg.
`timescale 1ns / 1ps

module pgibs_lane
  import pgibs_pkg::*;
(
  input  logic [1:0] geno_a_i,
  input  logic [1:0] geno_b_i,
  output lane_hit_t  hit_o
);

  logic       called;
  logic [1:0] diff;

  assign called = (geno_a_i != GenoMissing) && (geno_b_i != GenoMissing);
  assign diff   = (geno_a_i > geno_b_i) ? (geno_a_i - geno_b_i) : (geno_b_i - geno_a_i);

  always_comb begin
    hit_o.ibs0 = called && (diff == DiffTwo);
    hit_o.ibs1 = called && (diff == DiffOne);
    hit_o.ibs2 = called && (diff == DiffNone);
  end

endmodule

// ----- sv/pgibs_merge.sv -----
// Merge stage: population counts of the lane hits, per IBS class.
// Two-level adder tree (groups of four lanes, then group sums). Depends on pgibs_pkg.
`timescale 1ns / 1ps

module pgibs_merge
  import pgibs_pkg::*;
#(
  parameter int unsigned SNPS_PER_WORD = 16,
  parameter int unsigned CW            = 5
) (
  input  lane_hit_t         hits_i [SNPS_PER_WORD],
  output logic [CW-1:0]     n0_o,
  output logic [CW-1:0]     n1_o,
  output logic [CW-1:0]     n2_o
);

  localparam int unsigned Groups = (SNPS_PER_WORD + 3) / 4;

  logic [2:0] grp0 [Groups];
  logic [2:0] grp1 [Groups];
  logic [2:0] grp2 [Groups];

  // Sum each group of four lanes.
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp0[g] = '0;
      grp1[g] = '0;
      grp2[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < SNPS_PER_WORD) begin
          grp0[g] = grp0[g] + 3'(hits_i[g * 4 + k].ibs0);
          grp1[g] = grp1[g] + 3'(hits_i[g * 4 + k].ibs1);
          grp2[g] = grp2[g] + 3'(hits_i[g * 4 + k].ibs2);
        end
      end
    end
  end

  // Add up the group sums.
  always_comb begin
    n0_o = '0;
    n1_o = '0;
    n2_o = '0;
    for (int g = 0; g < Groups; g++) begin
      n0_o = n0_o + CW'(grp0[g]);
      n1_o = n1_o + CW'(grp1[g]);
      n2_o = n2_o + CW'(grp2[g]);
    end
  end

endmodule

// ----- sv/pgibs_accum.sv -----
// Saturating IBS accumulators and the registered result word.
// Depends on pgibs_pkg.
`timescale 1ns / 1ps

module pgibs_accum
  import pgibs_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned CW          = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  word_flags_t        flags_i,
  input  logic [CW-1:0]      n0_i,
  input  logic [CW-1:0]      n1_i,
  input  logic [CW-1:0]      n2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CntOutW-1:0] ibs0_o,
  output logic [CntOutW-1:0] ibs1_o,
  output logic [CntOutW-1:0] ibs2_o
);

  logic [COUNT_WIDTH-1:0] acc0_q, acc0_d;
  logic [COUNT_WIDTH-1:0] acc1_q, acc1_d;
  logic [COUNT_WIDTH-1:0] acc2_q, acc2_d;
  logic [CntOutW-1:0]     res0_q, res1_q, res2_q;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;
  logic                   take;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] base,
                                                     input logic [CW-1:0]          inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, base} + (COUNT_WIDTH + 1)'(inc);
    return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  endfunction

  // A word that emits needs room in the result register; others always pass.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !flags_i.last || out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    acc0_d = acc0_q;
    acc1_d = acc1_q;
    acc2_d = acc2_q;
    if (take) begin
      acc0_d = sat_add(flags_i.first ? '0 : acc0_q, n0_i);
      acc1_d = sat_add(flags_i.first ? '0 : acc1_q, n1_i);
      acc2_d = sat_add(flags_i.first ? '0 : acc2_q, n2_i);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && flags_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc0_q      <= '0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc0_q      <= acc0_d;
      acc1_q      <= acc1_d;
      acc2_q      <= acc2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && flags_i.last) begin
      res0_q <= CntOutW'(acc0_d);
      res1_q <= CntOutW'(acc1_d);
      res2_q <= CntOutW'(acc2_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ibs0_o      = res0_q;
  assign ibs1_o      = res1_q;
  assign ibs2_o      = res2_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_valid_i && flags_i.last) |-> !in_ready_o)
    else $error("emitting word accepted while result register is stalled");

  a_acc_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !flags_i.first) |=> (acc0_q >= $past(acc0_q)) && (acc1_q >= $past(acc1_q))
                                 && (acc2_q >= $past(acc2_q)))
    else $error("accumulator decreased without a first word");

  a_single_word_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && flags_i.first && flags_i.last) |=>
      (ibs0_o == CntOutW'($past(n0_i))) && (ibs1_o == CntOutW'($past(n1_i)))
      && (ibs2_o == CntOutW'($past(n2_i))))
    else $error("single-word run did not emit its own counts");
`endif

endmodule

// ----- sv/packed_genotype_ibs_counter.sv -----
// Top level of the packed genotype IBS counter: input stage, marker lanes,
// merge tree and accumulators. Depends on pgibs_pkg, pgibs_lane, pgibs_merge, pgibs_accum.
`timescale 1ns / 1ps

// Usage
//   Slave stream: each word carries SNPS_PER_WORD 2-bit genotype calls for two
//   samples (code 3 = missing). tuser marks the first word of a sample pair and
//   clears the three counts before that word is added; tlast marks the pair's
//   last word and emits one result word after it is added. Words with neither
//   mark keep adding to the running counts.
//   Master stream: one result word per tlast input word, holding the IBS0, IBS1
//   and IBS2 counts (saturating at COUNT_WIDTH bits, shown as 32-bit fields).
//   Throughput: one word per cycle unless a last word waits on a held result;
//   every marker slot has its own lane and a two-level adder tree merges the
//   lanes, so nothing iterates. Path: a tlast word passes the lane register
//   and count register, then m_axis_tvalid rises as the result register loads.
//   Stall: while a result waits, non-last words keep flowing into the counts;
//   a last word waits in the count register until the result is taken, and the
//   two pipeline registers fill before s_axis_tready drops.
//   Reset: clears the counts to zero and empties the pipeline and result.
module packed_genotype_ibs_counter
  import pgibs_pkg::*;
#(
  parameter int unsigned SNPS_PER_WORD = 16,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // genotypes_a, genotypes_b (each 2*SNPS_PER_WORD bits), zero padding
  input  logic [((4 * SNPS_PER_WORD + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // first_word
  input  logic                s_axis_tuser,
  // last_word
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ibs0_count [31:0], ibs1_count [63:32], ibs2_count [95:64]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned GenoW = 2 * SNPS_PER_WORD;
  localparam int unsigned CW    = $clog2(SNPS_PER_WORD + 1);

  logic [GenoW-1:0] geno_a;
  logic [GenoW-1:0] geno_b;

  lane_hit_t   hits_d [SNPS_PER_WORD];
  lane_hit_t   hits_q [SNPS_PER_WORD];
  word_flags_t s1_flags_q;
  logic        s1_valid_q, s1_valid_d;

  logic [CW-1:0] n0_d, n1_d, n2_d;
  logic [CW-1:0] n0_q, n1_q, n2_q;
  word_flags_t   s2_flags_q;
  logic          s2_valid_q, s2_valid_d;

  logic s1_can;
  logic s2_can;
  logic acc_ready;

  assign geno_a = s_axis_tdata[GenoW-1:0];
  assign geno_b = s_axis_tdata[2*GenoW-1:GenoW];

  // One lane per marker slot, straight off the input word.
  for (genvar i = 0; i < SNPS_PER_WORD; i++) begin : g_lane
    pgibs_lane u_lane (
      .geno_a_i (geno_a[2*i+1:2*i]),
      .geno_b_i (geno_b[2*i+1:2*i]),
      .hit_o    (hits_d[i])
    );
  end

  // A stage loads when it is empty or its word moves on.
  assign s2_can        = !s2_valid_q || acc_ready;
  assign s1_can        = !s1_valid_q || s2_can;
  assign s_axis_tready = s1_can;

  always_comb begin
    s1_valid_d = s1_can ? s_axis_tvalid : s1_valid_q;
    s2_valid_d = s2_can ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Lane register: hold the per-slot classes and run markers.
  always_ff @(posedge clk_i) begin
    if (s1_can) begin
      hits_q     <= hits_d;
      s1_flags_q <= '{first: s_axis_tuser, last: s_axis_tlast};
    end
  end

  pgibs_merge #(
    .SNPS_PER_WORD (SNPS_PER_WORD),
    .CW            (CW)
  ) u_merge (
    .hits_i (hits_q),
    .n0_o   (n0_d),
    .n1_o   (n1_d),
    .n2_o   (n2_d)
  );

  // Count register: per-word totals of each class.
  always_ff @(posedge clk_i) begin
    if (s2_can) begin
      n0_q       <= n0_d;
      n1_q       <= n1_d;
      n2_q       <= n2_d;
      s2_flags_q <= s1_flags_q;
    end
  end

  pgibs_accum #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .CW          (CW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_ready_o  (acc_ready),
    .flags_i     (s2_flags_q),
    .n0_i        (n0_q),
    .n1_i        (n1_q),
    .n2_i        (n2_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ibs0_o      (m_axis_tdata[CntOutW-1:0]),
    .ibs1_o      (m_axis_tdata[2*CntOutW-1:CntOutW]),
    .ibs2_o      (m_axis_tdata[3*CntOutW-1:2*CntOutW])
  );

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_can) |=> s1_valid_q && $stable(s1_flags_q))
    else $error("lane register lost a stalled word");
`endif

endmodule
